FILE: src/rbf_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the square-root step for the radial brush falloff block.
// Depends on nothing; used by rbf_sqrt_stage and radial_brush_falloff_weight_top.
package rbf_pkg;

	localparam int unsigned DistW  = 14;   // squared distance, padded to whole bit pairs
	localparam int unsigned RootW  = 25;   // root of the distance scaled by 2^36
	localparam int unsigned RemW   = 27;
	localparam int unsigned KW     = 8;    // divisor 4r+1
	localparam int unsigned NumW   = 26;
	localparam int unsigned DRemW  = 24;
	localparam int unsigned QW     = 16;
	localparam int unsigned WeightW = 17;
	localparam int unsigned StepsPerStage = 5;
	localparam int unsigned SqrtStages    = 5;
	localparam logic [WeightW-1:0] OneQ16 = 17'h10000;

	// Square-root recurrence state; the unconsumed radicand bits sit at the top of rad.
	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
		logic [DistW-1:0] rad;
	} sqrt_t;

	// Side information that travels with every item.
	typedef struct packed {
		logic [KW-1:0] k;
		logic          r0;
		logic          inr;
	} ctl_t;

	// One step of the restoring square root: takes two radicand bits.
	function automatic sqrt_t sqrt_step(input sqrt_t s);
		sqrt_t          o;
		logic [RemW:0]  t;
		logic [RemW:0]  trial;
		begin
			o = s;
			t = {s.rem[RemW-2:0], s.rad[DistW-1 -: 2]};
			trial = {1'b0, s.root, 2'b01};
			o.rad = {s.rad[DistW-3:0], 2'b00};
			if (t >= trial) begin
				o.rem  = RemW'(t - trial);
				o.root = {s.root[RootW-2:0], 1'b1};
			end else begin
				o.rem  = t[RemW-1:0];
				o.root = {s.root[RootW-2:0], 1'b0};
			end
			return o;
		end
	endfunction

endpackage

FILE: src/rbf_sqrt_stage.sv
`timescale 1ns / 1ps
// One registered stage of the pipelined square root: five recurrence steps.
// Depends on rbf_pkg for the state type and the step function.
module rbf_sqrt_stage (
	input  logic          clk,
	input  logic          en,
	input  rbf_pkg::sqrt_t d_in,
	input  rbf_pkg::ctl_t  c_in,
	output rbf_pkg::sqrt_t d_out,
	output rbf_pkg::ctl_t  c_out
);

	rbf_pkg::sqrt_t nxt;

	// Five dependent steps on the partial remainder and root.
	always_comb begin
		nxt = d_in;
		for (int i = 0; i < rbf_pkg::StepsPerStage; i++) begin
			nxt = rbf_pkg::sqrt_step(nxt);
		end
	end

	// Stage register, held while the pipeline stalls.
	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
			c_out <= c_in;
		end
	end

endmodule

FILE: src/radial_brush_falloff_weight_top.sv
`timescale 1ns / 1ps
// Radial brush falloff weight: a 13-stage pipeline from accept to result.
// Throughput is one item per cycle; the whole pipeline holds when the output is stalled.
// The square root takes five stages and the division by 4r+1 two stages.
// Reset clears all valid bits and sets the radius register to 0.
// Depends on rbf_pkg and rbf_sqrt_stage.
module radial_brush_falloff_weight_top #(
	parameter int unsigned RADIUS_MAX = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [8:0] pixel_x,
	input  logic signed [8:0] pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] weight,
	output logic        in_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  radius
);

	localparam int unsigned NStages = 13;

	logic [NStages-1:0] v_q;
	logic               adv;
	logic [5:0]         radius_q;
	logic [6:0]         r_sat;

	assign adv       = !v_q[NStages-1] || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = v_q[NStages-1];

	// Radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_valid) begin
			radius_q <= radius;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NStages-2:0], in_valid};
		end
	end

	// Stage 1: clamp radius, range check, offsets from the center.
	logic signed [9:0] dx_s1, dy_s1;
	rbf_pkg::ctl_t     c_s1;
	logic [7:0]        side;

	assign r_sat = ({1'b0, radius_q} > 7'(RADIUS_MAX)) ? 7'(RADIUS_MAX) : {1'b0, radius_q};
	assign side  = {r_sat, 1'b1};

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= 10'(pixel_x) - $signed({3'b000, r_sat});
			dy_s1   <= 10'(pixel_y) - $signed({3'b000, r_sat});
			c_s1.k  <= {r_sat[5:0], 2'b01};
			c_s1.r0 <= (r_sat == '0);
			c_s1.inr <= !pixel_x[8] && !pixel_y[8] &&
				({1'b0, pixel_x[7:0]} < {1'b0, side}) &&
				({1'b0, pixel_y[7:0]} < {1'b0, side});
		end
	end

	// Stage 2: squared distance.
	rbf_pkg::sqrt_t sq_in;
	rbf_pkg::ctl_t  c_s2;
	logic [19:0]    dxx, dyy;

	assign dxx = 20'(dx_s1 * dx_s1);
	assign dyy = 20'(dy_s1 * dy_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_in.rem  <= '0;
			sq_in.root <= '0;
			sq_in.rad  <= rbf_pkg::DistW'(dxx + dyy);
			c_s2       <= c_s1;
		end
	end

	// Stages 3 to 7: square root of the distance scaled by 2^36.
	rbf_pkg::sqrt_t sq_d [rbf_pkg::SqrtStages+1];
	rbf_pkg::ctl_t  sq_c [rbf_pkg::SqrtStages+1];

	assign sq_d[0] = sq_in;
	assign sq_c[0] = c_s2;

	for (genvar g = 0; g < rbf_pkg::SqrtStages; g++) begin : g_sqrt
		rbf_sqrt_stage u_stage (
			.clk  (clk),
			.en   (adv),
			.d_in (sq_d[g]),
			.c_in (sq_c[g]),
			.d_out(sq_d[g+1]),
			.c_out(sq_c[g+1])
		);
	end

	// Stage 8: round the root up, form the ceiling numerator, test for saturation.
	rbf_pkg::sqrt_t           sq_f;
	logic [rbf_pkg::NumW-1:0] num;
	logic [rbf_pkg::DRemW-1:0] drem_s8;
	logic                     sat_s8;
	rbf_pkg::ctl_t            c_s8;

	assign sq_f = sq_d[rbf_pkg::SqrtStages];
	assign num  = rbf_pkg::NumW'(sq_f.root) + rbf_pkg::NumW'(sq_f.rem != '0)
		+ rbf_pkg::NumW'(sq_c[rbf_pkg::SqrtStages].k) - 1'b1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s8  <= num >= {2'b00, sq_c[rbf_pkg::SqrtStages].k, 16'h0000};
			drem_s8 <= num[rbf_pkg::DRemW-1:0];
			c_s8    <= sq_c[rbf_pkg::SqrtStages];
		end
	end

	// Stages 9 and 10: restoring division, eight quotient bits per stage.
	logic [rbf_pkg::DRemW-1:0] drem_s9;
	logic [7:0]                qh_s9;
	logic [rbf_pkg::QW-1:0]    q_s10;
	logic                      sat_s9, sat_s10;
	rbf_pkg::ctl_t             c_s9, c_s10;
	logic [rbf_pkg::DRemW-1:0] r9, r10;
	logic [7:0]                qh9, ql10;

	always_comb begin
		r9 = drem_s8;
		qh9 = '0;
		for (int i = 7; i >= 0; i--) begin
			if (r9 >= (rbf_pkg::DRemW'(c_s8.k) << (i + 8))) begin
				r9 = r9 - (rbf_pkg::DRemW'(c_s8.k) << (i + 8));
				qh9[i] = 1'b1;
			end
		end
	end

	always_comb begin
		r10 = drem_s9;
		ql10 = '0;
		for (int i = 7; i >= 0; i--) begin
			if (r10 >= (rbf_pkg::DRemW'(c_s9.k) << i)) begin
				r10 = r10 - (rbf_pkg::DRemW'(c_s9.k) << i);
				ql10[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drem_s9  <= r9;
			qh_s9    <= qh9;
			sat_s9   <= sat_s8;
			c_s9     <= c_s8;
			q_s10    <= {qh_s9, ql10};
			sat_s10  <= sat_s9;
			c_s10    <= c_s9;
		end
	end

	// Stage 11: n = 1 - c, clamped at zero.
	logic [16:0]   n_s11;
	rbf_pkg::ctl_t c_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s11 <= sat_s10 ? 17'd0 : rbf_pkg::OneQ16 - {1'b0, q_s10};
			c_s11 <= c_s10;
		end
	end

	// Stage 12: square of n.
	logic [33:0]   p_s12;
	rbf_pkg::ctl_t c_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s12 <= n_s11 * n_s11;
			c_s12 <= c_s11;
		end
	end

	// Stage 13: output register with the zero-radius and outside-grid cases.
	logic [16:0] w_s13;
	logic        inr_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s13 <= c_s12.inr;
			if (!c_s12.inr) begin
				w_s13 <= '0;
			end else if (c_s12.r0) begin
				w_s13 <= rbf_pkg::OneQ16;
			end else begin
				w_s13 <= p_s12[32:16];
			end
		end
	end

	assign weight   = w_s13;
	assign in_range = inr_s13;

endmodule

FILE: tb/sv/tb_radial_brush_falloff_weight_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the radial brush falloff weight pipeline.
// Depends on rbf_pkg and radial_brush_falloff_weight_top; a local predictor checks every result.
module tb_radial_brush_falloff_weight_top;

	localparam int RMAX = 63;

	typedef struct {
		logic [16:0] weight;
		logic        in_range;
	} falloff_t;

	typedef struct {
		int          x;
		int          y;
		bit          known;
		logic [16:0] weight;
		logic        in_range;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic signed [8:0] pixel_x = '0;
	logic signed [8:0] pixel_y = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [16:0]       weight;
	logic              in_range;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [5:0]        radius = '0;

	falloff_t pending_weights[$];
	int       cur_radius = 0;
	int       fails = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	bit       hold_off = 1'b0;

	radial_brush_falloff_weight_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.weight(weight), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .radius(radius)
	);

	// Clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit.
	initial begin
		#60ms;
		$display("radial_brush_falloff_weight_top: mismatch");
		$finish;
	end

	// Ceiling of the exact square root of v.
	function automatic longint unsigned root_ceil(longint unsigned v);
		longint unsigned lo, hi, mid;
		begin
			lo = 0;
			hi = 64'd1 << 32;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (mid * mid >= v) hi = mid;
				else lo = mid + 1;
			end
			return lo;
		end
	endfunction

	// Predicted weight of one grid cell at the current radius.
	function automatic falloff_t predict_falloff(int x, int y);
		falloff_t        f;
		int              r, side, dx, dy;
		longint unsigned s, k, c, n16;
		begin
			r = (cur_radius > RMAX) ? RMAX : cur_radius;
			side = 2 * r + 1;
			f.weight = '0;
			f.in_range = 1'b0;
			if (x < 0 || x >= side || y < 0 || y >= side) return f;
			dx = x - r;
			dy = y - r;
			s = root_ceil(longint'(dx * dx + dy * dy) << 36);
			k = 4 * r + 1;
			c = (s + k - 1) / k;
			n16 = (c < 65536) ? 65536 - c : 0;
			f.weight = (r == 0) ? rbf_pkg::OneQ16 : 17'((n16 * n16) >> 16);
			f.in_range = 1'b1;
			return f;
		end
	endfunction

	// Offer one coordinate and record its expected weight once accepted.
	task automatic send_pixel(int x, int y);
		begin
			while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			pixel_x <= 9'(x);
			pixel_y <= 9'(y);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			pending_weights.push_back(predict_falloff(x, y));
		end
	endtask

	// Write the radius once the pipeline has drained.
	task automatic write_radius(int r);
		begin
			in_valid <= 1'b0;
			while (pending_weights.size() != 0) @(posedge clk);
			repeat (16) @(posedge clk);
			cfg_valid <= 1'b1;
			radius <= 6'(r);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_valid <= 1'b0;
			cur_radius = r;
		end
	endtask

	// Receiver: random stalls plus an optional long hold-off.
	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		falloff_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_weights.size() == 0) begin
				$display("%0t: unexpected result weight=%0d in_range=%0b", $time, weight,
					in_range);
				fails++;
			end else begin
				e = pending_weights.pop_front();
				if (weight !== e.weight) begin
					$display("%0t: weight expected %0d actual %0d", $time, e.weight, weight);
					fails++;
				end
				if (in_range !== e.in_range) begin
					$display("%0t: in_range expected %0b actual %0b", $time, e.in_range,
						in_range);
					fails++;
				end
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering items.
	task automatic stall_receiver();
		int n;
		begin
			hold_off = 1'b1;
			n = 0;
			while (n < 60) begin
				@(posedge clk);
				n++;
			end
			hold_off = 1'b0;
		end
	endtask

	// Stimulus: directed table first, then extreme and small radii, then random phases.
	initial begin
		row_t            rows[$];
		row_t            row;
		falloff_t        got;
		int              radii[$];
		int              phase, i, r, side, waitc;
		row = '{0, 0, 1, rbf_pkg::OneQ16, 1'b1}; rows.push_back(row);
		row = '{1, 0, 1, 17'd0, 1'b0}; rows.push_back(row);
		row = '{0, 1, 1, 17'd0, 1'b0}; rows.push_back(row);
		row = '{-1, 0, 1, 17'd0, 1'b0}; rows.push_back(row);
		row = '{0, -256, 1, 17'd0, 1'b0}; rows.push_back(row);
		row = '{255, 255, 1, 17'd0, 1'b0}; rows.push_back(row);
		row = '{-256, -1, 1, 17'd0, 1'b0}; rows.push_back(row);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Radius 0 after reset: the single cell and out-of-grid points.
		foreach (rows[j]) begin
			send_pixel(rows[j].x, rows[j].y);
			got = pending_weights[$];
			if (rows[j].known && (got.weight !== rows[j].weight
					|| got.in_range !== rows[j].in_range)) begin
				$display("%0t: table row %0d expected %0d/%0b actual %0d/%0b", $time, j,
					rows[j].weight, rows[j].in_range, got.weight, got.in_range);
				fails++;
			end
		end

		// Extreme radius: centre, corners, rim, just outside.
		write_radius(63);
		send_pixel(63, 63);
		send_pixel(0, 0);
		send_pixel(126, 126);
		send_pixel(126, 63);
		send_pixel(63, 0);
		send_pixel(127, 63);
		send_pixel(63, 127);
		send_pixel(0, 126);
		send_pixel(-256, 255);
		write_radius(1);
		send_pixel(1, 1);
		send_pixel(0, 1);
		send_pixel(2, 2);
		send_pixel(3, 0);

		// Random phases across idling modes and radii.
		radii = '{0, 63, 1, 5, 31, 17, 63, 2, 42, 10, 0, 63};
		for (phase = 0; phase < 12; phase++) begin
			write_radius((phase < 11 && phase % 3 == 2) ? $urandom_range(63) : radii[phase]);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			if (phase == 4) fork stall_receiver(); join_none
			r = cur_radius;
			side = 2 * r + 1;
			for (i = 0; i < 155; i++) begin
				if ($urandom_range(9) < 8)
					send_pixel($urandom_range(side - 1), $urandom_range(side - 1));
				else
					send_pixel(int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256);
			end
		end

		// Drain and finish.
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		waitc = 0;
		while (pending_weights.size() != 0 && waitc < 100000) begin
			@(posedge clk);
			waitc++;
		end
		repeat (20) @(posedge clk);
		if (fails == 0 && pending_weights.size() == 0)
			$display("radial_brush_falloff_weight_top: match");
		else
			$display("radial_brush_falloff_weight_top: mismatch");
		$finish;
	end

endmodule
